// File: hw/rtl/mbhr_pkg.sv
// ---------------------------------------------------------------------------
// mbhr_pkg
// Shared types and constants for the holding-register server.
// ---------------------------------------------------------------------------
package mbhr_pkg;

  localparam int HOLD_REGS_DEF = 128;
  localparam int HDR_DEPTH     = 10;

  // function codes
  localparam logic [7:0] FC_READ    = 8'h03;
  localparam logic [7:0] FC_WSINGLE = 8'h06;
  localparam logic [7:0] FC_WMUL    = 8'h10;
  localparam logic [7:0] FC_RW      = 8'h17;
  localparam logic [7:0] FC_EXC     = 8'h80;

  // count limits
  localparam logic [15:0] CNT_MIN      = 16'h0001;
  localparam logic [15:0] READ_CNT_MAX = 16'h007D;
  localparam logic [15:0] WMUL_CNT_MAX = 16'h0078;
  localparam logic [15:0] RW_WCNT_MAX  = 16'h0079;

  // exception codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_ILL_FUNC  = 2'd1;
  localparam logic [1:0] ERR_ILL_ADDR  = 2'd2;
  localparam logic [1:0] ERR_ILL_VALUE = 2'd3;

  // configuration register indexes
  localparam logic CFG_WINDOW_START = 1'b0;
  localparam logic CFG_WINDOW_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REQ,
    ST_FRD,
    ST_FOUT
  } state_t;

  typedef struct packed {
    logic clear_en;
    logic capture;
    logic do_req;
    logic do_read;
    logic do_fetch;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } ctrl_status_t;

endpackage

// File: hw/rtl/modbus_holding_register_slave.sv
// ---------------------------------------------------------------------------
// modbus_holding_register_slave
// Holding-register server for functions 03h, 06h, 10h and 17h at PDU level.
// ---------------------------------------------------------------------------
// After reset the block sweeps the register file to zero, one word per
// cycle, and holds in_stall high meanwhile. A request byte is then
// accepted, then parsed with at most one register file write. A fetch is
// accepted, the register file is read, and the word is formatted into the
// output register once that register is no longer blocked. The sequencer
// handles one word at a time. Configuration is written through cfg_we.
module modbus_holding_register_slave #(
  parameter int HOLD_REGS = mbhr_pkg::HOLD_REGS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [7:0]  pdu_byte,
  input  logic        pdu_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  resp_byte,
  output logic        resp_last,
  output logic        resp_empty
);

  mbhr_pkg::ctrl_cmd_t    ctl;
  mbhr_pkg::ctrl_status_t status;

  mbhr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .in_stall (in_stall),
    .status   (status),
    .ctl      (ctl)
  );

  mbhr_dp #(
    .HOLD_REGS (HOLD_REGS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .status     (status),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pdu_byte   (pdu_byte),
    .pdu_last   (pdu_last),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .resp_byte  (resp_byte),
    .resp_last  (resp_last),
    .resp_empty (resp_empty)
  );

endmodule

// File: hw/rtl/mbhr_ctrl.sv
// ---------------------------------------------------------------------------
// mbhr_ctrl
// Sequencer: register file clearing pass, then one word at a time.
// ---------------------------------------------------------------------------
module mbhr_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  cmd,
  output logic                  in_stall,
  input  mbhr_pkg::ctrl_status_t status,
  output mbhr_pkg::ctrl_cmd_t    ctl
);

  mbhr_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mbhr_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_stall   = 1'b1;
    case (state)
      mbhr_pkg::ST_CLEAR: begin
        ctl.clear_en = 1'b1;
        if (status.clear_last) begin
          state_next = mbhr_pkg::ST_IDLE;
        end
      end
      mbhr_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctl.capture = 1'b1;
          state_next  = cmd ? mbhr_pkg::ST_FRD : mbhr_pkg::ST_REQ;
        end
      end
      mbhr_pkg::ST_REQ: begin
        ctl.do_req = 1'b1;
        state_next = mbhr_pkg::ST_IDLE;
      end
      mbhr_pkg::ST_FRD: begin
        ctl.do_read = 1'b1;
        state_next  = mbhr_pkg::ST_FOUT;
      end
      mbhr_pkg::ST_FOUT: begin
        // hold until the output register can take the word
        if (status.out_free) begin
          ctl.do_fetch = 1'b1;
          state_next   = mbhr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mbhr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/mbhr_dp.sv
// ---------------------------------------------------------------------------
// mbhr_dp
// Request parsing, register file, response formatting and output register.
// ---------------------------------------------------------------------------
module mbhr_dp #(
  parameter int HOLD_REGS = mbhr_pkg::HOLD_REGS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mbhr_pkg::ctrl_cmd_t    ctl,
  output mbhr_pkg::ctrl_status_t status,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic [7:0]             pdu_byte,
  input  logic                   pdu_last,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             resp_byte,
  output logic                   resp_last,
  output logic                   resp_empty
);

  localparam int          AW      = (HOLD_REGS > 1) ? $clog2(HOLD_REGS) : 1;
  localparam logic [16:0] DEPTH17 = 17'(HOLD_REGS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HOLD_REGS - 1);
  localparam int          HD      = mbhr_pkg::HDR_DEPTH;

  // configuration
  logic [15:0] window_start;
  logic [7:0]  window_count;
  logic [7:0]  eff_count;

  // request/response state
  logic [7:0]  hdr [HD];
  logic [7:0]  req_index;
  logic [15:0] wp;
  logic [7:0]  phb;
  logic [1:0]  err;
  logic [7:0]  rsp_index;
  logic        pending;

  // captured word
  logic [7:0]  b_q;
  logic        last_q;

  // register file
  logic [15:0]   mem [HOLD_REGS];
  logic [AW-1:0] clr_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;
  logic [15:0]   rdata;
  logic          rd_ok;

  // request step
  logic [7:0]  hdr_n [HD];
  logic [7:0]  req_index_n;
  logic [15:0] wp_n;
  logic [7:0]  phb_n;
  logic [1:0]  err_n;
  logic [7:0]  rsp_index_n;
  logic        pending_n;
  logic        req_we;
  logic [15:0] req_waddr;
  logic [15:0] req_wdata;

  function automatic logic in_window(input logic [15:0] addr, input logic [15:0] cnt,
                                     input logic [15:0] ws, input logic [7:0] eff);
    logic [17:0] lo;
    logic [17:0] hi;
    lo = {2'b0, addr} + {2'b0, cnt};
    hi = {2'b0, ws} + {10'b0, eff};
    return (addr >= ws) && (lo <= hi);
  endfunction

  assign eff_count = ({24'b0, window_count} > 32'(HOLD_REGS)) ? 8'(HOLD_REGS) : window_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= '0;
      window_count <= 8'd128;
    end else if (cfg_we) begin
      if (cfg_index == mbhr_pkg::CFG_WINDOW_START) begin
        window_start <= cfg_data;
      end else begin
        window_count <= cfg_data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      b_q    <= pdu_byte;
      last_q <= pdu_last;
    end
  end

  always_comb begin
    logic        first;
    logic [7:0]  fc;
    logic [3:0]  hlen;
    logic [15:0] w1, w3, w5, w7, wcnt;
    logic [8:0]  idx1;
    logic [7:0]  d;
    first = (req_index == 8'd0);
    for (int k = 0; k < HD; k++) begin
      hdr_n[k] = first ? 8'd0 : hdr[k];
    end
    if (req_index < 8'(HD)) begin
      hdr_n[req_index[3:0]] = b_q;
    end
    fc = hdr_n[0];
    case (fc)
      mbhr_pkg::FC_READ:    hlen = 4'd5;
      mbhr_pkg::FC_WSINGLE: hlen = 4'd5;
      mbhr_pkg::FC_WMUL:    hlen = 4'd6;
      mbhr_pkg::FC_RW:      hlen = 4'd10;
      default:              hlen = 4'd1;
    endcase
    w1 = {hdr_n[1], hdr_n[2]};
    w3 = {hdr_n[3], hdr_n[4]};
    w5 = {hdr_n[5], hdr_n[6]};
    w7 = {hdr_n[7], hdr_n[8]};
    wcnt = (fc == mbhr_pkg::FC_WMUL) ? w3 : w7;
    idx1 = {1'b0, req_index} + 9'd1;
    d    = req_index - {4'b0, hlen};

    err_n = err;
    if (first) begin
      if (b_q != mbhr_pkg::FC_READ && b_q != mbhr_pkg::FC_WSINGLE &&
          b_q != mbhr_pkg::FC_WMUL && b_q != mbhr_pkg::FC_RW) begin
        err_n = mbhr_pkg::ERR_ILL_FUNC;
      end else begin
        err_n = mbhr_pkg::ERR_NONE;
      end
    end
    wp_n        = first ? 16'd0 : wp;
    phb_n       = first ? 8'd0 : phb;
    rsp_index_n = first ? 8'd0 : rsp_index;
    pending_n   = first ? 1'b0 : pending;
    req_we      = 1'b0;
    req_waddr   = wp_n;
    req_wdata   = {phb_n, b_q};

    if (err_n == mbhr_pkg::ERR_NONE) begin
      if (idx1 == {5'b0, hlen}) begin
        case (fc)
          mbhr_pkg::FC_READ: begin
            if (w3 < mbhr_pkg::CNT_MIN || w3 > mbhr_pkg::READ_CNT_MAX) begin
              err_n = mbhr_pkg::ERR_ILL_VALUE;
            end else if (!in_window(w1, w3, window_start, eff_count)) begin
              err_n = mbhr_pkg::ERR_ILL_ADDR;
            end
          end
          mbhr_pkg::FC_WSINGLE: begin
            if (!in_window(w1, 16'd1, window_start, eff_count)) begin
              err_n = mbhr_pkg::ERR_ILL_ADDR;
            end else begin
              req_we    = 1'b1;
              req_waddr = w1 - window_start;
              req_wdata = w3;
            end
          end
          mbhr_pkg::FC_WMUL: begin
            if (w3 < mbhr_pkg::CNT_MIN || w3 > mbhr_pkg::WMUL_CNT_MAX ||
                {9'b0, hdr_n[5]} != {w3, 1'b0}) begin
              err_n = mbhr_pkg::ERR_ILL_VALUE;
            end else if (!in_window(w1, w3, window_start, eff_count)) begin
              err_n = mbhr_pkg::ERR_ILL_ADDR;
            end else begin
              wp_n = w1 - window_start;
            end
          end
          default: begin
            if (w3 < mbhr_pkg::CNT_MIN || w3 > mbhr_pkg::READ_CNT_MAX ||
                w7 < mbhr_pkg::CNT_MIN || w7 > mbhr_pkg::RW_WCNT_MAX ||
                {9'b0, hdr_n[9]} != {w7, 1'b0}) begin
              err_n = mbhr_pkg::ERR_ILL_VALUE;
            end else if (!in_window(w1, w3, window_start, eff_count) ||
                         !in_window(w5, w7, window_start, eff_count)) begin
              err_n = mbhr_pkg::ERR_ILL_ADDR;
            end else begin
              wp_n = w5 - window_start;
            end
          end
        endcase
      end else if (req_index >= {4'b0, hlen} &&
                   (fc == mbhr_pkg::FC_WMUL || fc == mbhr_pkg::FC_RW)) begin
        if ({9'b0, d[7:1]} < wcnt) begin
          if (!d[0]) begin
            phb_n = b_q;
          end else begin
            req_we    = 1'b1;
            req_waddr = wp_n;
            req_wdata = {phb_n, b_q};
            wp_n      = wp_n + 16'd1;
          end
        end
      end
    end

    req_index_n = (req_index == 8'hFF) ? req_index : req_index + 8'd1;

    if (last_q) begin
      if (err_n == mbhr_pkg::ERR_NONE && idx1 < {5'b0, hlen}) begin
        err_n = mbhr_pkg::ERR_ILL_VALUE;
      end
      if (err_n == mbhr_pkg::ERR_NONE && (fc == mbhr_pkg::FC_READ || fc == mbhr_pkg::FC_RW)) begin
        wp_n = w1 - window_start;
      end
      req_index_n = 8'd0;
      rsp_index_n = 8'd0;
      pending_n   = 1'b1;
    end
  end

  // register file write port: clearing pass or request write
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 16'd0;
    if (ctl.clear_en) begin
      mem_we = 1'b1;
    end else if (ctl.do_req && req_we && ({1'b0, req_waddr} < DEPTH17)) begin
      mem_we    = 1'b1;
      mem_waddr = req_waddr[AW-1:0];
      mem_wdata = req_wdata;
    end
  end

  assign status.clear_last = (clr_addr == LAST_ADDR);

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (ctl.clear_en) begin
      clr_addr <= clr_addr + AW'(1);
    end
  end

  // response read address
  logic [7:0]  im2;
  logic [16:0] rd_sum;
  assign im2    = rsp_index - 8'd2;
  assign rd_sum = {1'b0, wp} + {10'b0, im2[7:1]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (ctl.do_read) begin
      rdata <= mem[rd_sum[AW-1:0]];
      rd_ok <= (rd_sum < DEPTH17);
    end
  end

  // response formatting
  logic [17:0] rsp_len;
  logic        rsp_end;
  logic [7:0]  rsp_b;
  logic [15:0] rword;
  logic [15:0] hw3;

  assign hw3   = {hdr[3], hdr[4]};
  assign rword = rd_ok ? rdata : 16'd0;

  always_comb begin
    if (err != mbhr_pkg::ERR_NONE) begin
      rsp_len = 18'd2;
    end else if (hdr[0] == mbhr_pkg::FC_READ || hdr[0] == mbhr_pkg::FC_RW) begin
      rsp_len = 18'd2 + {1'b0, hw3, 1'b0};
    end else begin
      rsp_len = 18'd5;
    end
    rsp_end = ({10'b0, rsp_index} + 18'd1) >= rsp_len;

    if (err != mbhr_pkg::ERR_NONE) begin
      rsp_b = (rsp_index == 8'd0) ? (hdr[0] | mbhr_pkg::FC_EXC) : {6'b0, err};
    end else if (hdr[0] == mbhr_pkg::FC_WSINGLE || hdr[0] == mbhr_pkg::FC_WMUL) begin
      if (rsp_index == 8'd0) begin
        rsp_b = hdr[0];
      end else if (rsp_index < 8'd5) begin
        rsp_b = hdr[rsp_index[3:0]];
      end else begin
        rsp_b = 8'd0;
      end
    end else if (rsp_index == 8'd0) begin
      rsp_b = hdr[0];
    end else if (rsp_index == 8'd1) begin
      rsp_b = {hw3[6:0], 1'b0};
    end else begin
      rsp_b = rsp_index[0] ? rword[7:0] : rword[15:8];
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < HD; k++) begin
        hdr[k] <= 8'd0;
      end
      req_index <= '0;
      wp        <= '0;
      phb       <= '0;
      err       <= mbhr_pkg::ERR_NONE;
      rsp_index <= '0;
      pending   <= 1'b0;
    end else if (ctl.do_req) begin
      hdr       <= hdr_n;
      req_index <= req_index_n;
      wp        <= wp_n;
      phb       <= phb_n;
      err       <= err_n;
      rsp_index <= rsp_index_n;
      pending   <= pending_n;
    end else if (ctl.do_fetch && pending) begin
      if (rsp_end) begin
        pending   <= 1'b0;
        rsp_index <= 8'd0;
      end else begin
        rsp_index <= rsp_index + 8'd1;
      end
    end
  end

  // output register
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.do_fetch) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_fetch) begin
      resp_byte  <= pending ? rsp_b : 8'd0;
      resp_last  <= pending && rsp_end;
      resp_empty <= !pending;
    end
  end

  a_fetch_free: assert property (@(posedge clk) disable iff (rst)
    ctl.do_fetch |-> (!out_valid || !out_stall))
    else $error("fetch word loaded while output register blocked");

  a_last_pends: assert property (@(posedge clk) disable iff (rst)
    (ctl.do_req && last_q) |=> (pending && req_index == 8'd0 && rsp_index == 8'd0))
    else $error("final request byte did not arm the response");

  a_no_write_on_fetch: assert property (@(posedge clk) disable iff (rst)
    (ctl.do_read || ctl.do_fetch) |-> !mem_we)
    else $error("register file written during a fetch");

endmodule
